// ===== src/serial_port_dual_ring_buffer_core_macros.svh =====
// ---------------------------------------------------------------------------
// serial port dual ring buffer - assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SERIAL_PORT_DUAL_RING_BUFFER_CORE_MACROS_SVH
`define SERIAL_PORT_DUAL_RING_BUFFER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SPDRB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spdrb check failed");

// next-cycle implication, sampled on clk, off while in reset
`define SPDRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spdrb check failed");

`endif

// ===== src/spdrb_pkg.sv =====
// ---------------------------------------------------------------------------
// spdrb_pkg
// types and constants shared by the serial port dual ring buffer
// ---------------------------------------------------------------------------
package spdrb_pkg;

  localparam int TX_DEPTH_DEF = 64;
  localparam int RX_DEPTH_DEF = 64;

  // request codes
  localparam logic [1:0] REQ_TX_WRITE = 2'd0;
  localparam logic [1:0] REQ_RX_READ  = 2'd1;
  localparam logic [1:0] REQ_LINE_RX  = 2'd2;
  localparam logic [1:0] REQ_TX_READY = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic       data_valid;
    logic [7:0] data_out;
    logic       rx_dropped;
    logic [5:0] rx_count;
    logic       tx_empty;
    logic       send_request;
  } out_item_t;

endpackage

// ===== src/spdrb_ram.sv =====
// ---------------------------------------------------------------------------
// spdrb_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module spdrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/serial_port_dual_ring_buffer_core.sv =====
// ---------------------------------------------------------------------------
// serial_port_dual_ring_buffer_core
// transmit and receive byte rings of a serial port, one event per beat
// ---------------------------------------------------------------------------
// usage
//   input channel: an event beat (req_type, data_in) is taken at a rising
//   edge where start is high and busy is low. busy stays low: every cycle
//   can carry a new event, so the sustained rate is one event per cycle.
//   result channel: each event gives exactly one result beat, on out_item
//   with out_valid high, in the cycle right after the event was taken; the
//   popped byte is handed out by the registered read port of the ring rams.
//   the receiver cannot stall: the result stands for one cycle only.
//   each ring keeps one slot free, so it holds at most depth minus one bytes.
//   each event writes or reads at most one entry of one ring ram, and a
//   write is visible to a read in the next cycle, so no forwarding
//   is needed between back-to-back events.
//   reset (synchronous, rst_n low) empties both rings by clearing the
//   pointers, drops the send request and kills any pending result beat.
//   ram contents are not cleared; only written entries are ever read.
// ---------------------------------------------------------------------------
module serial_port_dual_ring_buffer_core #(
  parameter int TX_DEPTH = spdrb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = spdrb_pkg::RX_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  spdrb_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output spdrb_pkg::out_item_t out_item
);

  import spdrb_pkg::*;

  localparam int TAW = $clog2(TX_DEPTH);
  localparam int RAW = $clog2(RX_DEPTH);
  localparam int RCW = RAW + 1;

  // where the result byte comes from
  typedef enum logic [1:0] {
    DSRC_NONE,
    DSRC_TX,
    DSRC_RX,
    DSRC_ECHO
  } dsrc_t;

  // ring pointers
  logic [TAW-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt, tx_wp_inc, tx_rp_inc;
  logic [RAW-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt, rx_wp_inc, rx_rp_inc;
  logic           send_en_r, send_en_nxt;

  // result registers
  logic           out_valid_r;
  logic           ok_r, ok_nxt;
  logic           dv_r, dv_nxt;
  logic           drop_r, drop_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic           txe_r;
  dsrc_t          dsrc_r, dsrc_nxt;
  logic [7:0]     echo_r;

  // ram controls
  logic           tx_we, tx_re, rx_we, rx_re;
  logic [7:0]     tx_rdata, rx_rdata;

  logic           accept;
  logic           tx_full, tx_emp, rx_full, rx_emp;
  logic [RCW-1:0] rx_diff;
  logic [31:0]    rx_diff_ext;

  // one event per cycle, never held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // pointer increments with wrap at depth minus one
  assign tx_wp_inc = (tx_wp_r == TAW'(TX_DEPTH - 1)) ? '0 : tx_wp_r + 1'b1;
  assign tx_rp_inc = (tx_rp_r == TAW'(TX_DEPTH - 1)) ? '0 : tx_rp_r + 1'b1;
  assign rx_wp_inc = (rx_wp_r == RAW'(RX_DEPTH - 1)) ? '0 : rx_wp_r + 1'b1;
  assign rx_rp_inc = (rx_rp_r == RAW'(RX_DEPTH - 1)) ? '0 : rx_rp_r + 1'b1;

  // one slot kept free: full when the next write slot is the read slot
  assign tx_full = (tx_wp_inc == tx_rp_r);
  assign tx_emp  = (tx_wp_r == tx_rp_r);
  assign rx_full = (rx_wp_inc == rx_rp_r);
  assign rx_emp  = (rx_wp_r == rx_rp_r);

  // event decode
  always_comb begin
    tx_wp_nxt   = tx_wp_r;
    tx_rp_nxt   = tx_rp_r;
    rx_wp_nxt   = rx_wp_r;
    rx_rp_nxt   = rx_rp_r;
    send_en_nxt = send_en_r;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    ok_nxt      = 1'b0;
    dv_nxt      = 1'b0;
    drop_nxt    = 1'b0;
    dsrc_nxt    = DSRC_NONE;
    if (accept) begin
      unique case (in_item.req_type)
        REQ_TX_WRITE: begin
          if (!tx_full) begin
            tx_we       = 1'b1;
            tx_wp_nxt   = tx_wp_inc;
            send_en_nxt = 1'b1;
            ok_nxt      = 1'b1;
          end
        end
        REQ_RX_READ: begin
          if (!rx_emp) begin
            rx_re     = 1'b1;
            rx_rp_nxt = rx_rp_inc;
            ok_nxt    = 1'b1;
            dv_nxt    = 1'b1;
            dsrc_nxt  = DSRC_RX;
          end
        end
        REQ_LINE_RX: begin
          // line byte is always echoed, stored only when there is room
          if (!rx_full) begin
            rx_we     = 1'b1;
            rx_wp_nxt = rx_wp_inc;
            ok_nxt    = 1'b1;
          end else begin
            drop_nxt  = 1'b1;
          end
          dv_nxt   = 1'b1;
          dsrc_nxt = DSRC_ECHO;
        end
        REQ_TX_READY: begin
          if (tx_emp) begin
            send_en_nxt = 1'b0;
          end else begin
            tx_re     = 1'b1;
            tx_rp_nxt = tx_rp_inc;
            ok_nxt    = 1'b1;
            dv_nxt    = 1'b1;
            dsrc_nxt  = DSRC_TX;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // receive fill level after the event, reported modulo 64
  always_comb begin
    rx_diff = {1'b0, rx_wp_nxt} - {1'b0, rx_rp_nxt};
    if (rx_wp_nxt < rx_rp_nxt) begin
      rx_diff = rx_diff + RCW'(RX_DEPTH);
    end
    rx_diff_ext = 32'(rx_diff);
    cnt_nxt     = rx_diff_ext[5:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wp_r     <= '0;
      tx_rp_r     <= '0;
      rx_wp_r     <= '0;
      rx_rp_r     <= '0;
      send_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
      dsrc_r      <= DSRC_NONE;
    end else begin
      tx_wp_r     <= tx_wp_nxt;
      tx_rp_r     <= tx_rp_nxt;
      rx_wp_r     <= rx_wp_nxt;
      rx_rp_r     <= rx_rp_nxt;
      send_en_r   <= send_en_nxt;
      out_valid_r <= accept;
      dsrc_r      <= dsrc_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    dv_r   <= dv_nxt;
    drop_r <= drop_nxt;
    cnt_r  <= cnt_nxt;
    txe_r  <= (tx_wp_nxt == tx_rp_nxt);
    echo_r <= in_item.data_in;
  end

  // transmit ring storage
  spdrb_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wp_r),
    .wdata (in_item.data_in),
    .re    (tx_re),
    .raddr (tx_rp_r),
    .rdata (tx_rdata)
  );

  // receive ring storage
  spdrb_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wp_r),
    .wdata (in_item.data_in),
    .re    (rx_re),
    .raddr (rx_rp_r),
    .rdata (rx_rdata)
  );

  // result beat
  always_comb begin
    out_item.ok           = ok_r;
    out_item.data_valid   = dv_r;
    out_item.rx_dropped   = drop_r;
    out_item.rx_count     = cnt_r;
    out_item.tx_empty     = txe_r;
    out_item.send_request = send_en_r;
    unique case (dsrc_r)
      DSRC_TX:   out_item.data_out = tx_rdata;
      DSRC_RX:   out_item.data_out = rx_rdata;
      DSRC_ECHO: out_item.data_out = echo_r;
      default:   out_item.data_out = 8'h00;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/spdrb_chk.sv =====
// ---------------------------------------------------------------------------
// spdrb_chk
// port-level checks for the serial port dual ring buffer, bound to the top
// ---------------------------------------------------------------------------
`include "serial_port_dual_ring_buffer_core_macros.svh"

module spdrb_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input spdrb_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input spdrb_pkg::out_item_t out_item
);

  import spdrb_pkg::*;

  // every taken event gives a result beat in the next cycle
  `SPDRB_ASSERT_NEXT(a_one_result, start && !busy, out_valid)

  // no result beat without an event taken the cycle before
  `SPDRB_ASSERT_NOW(a_no_spurious, out_valid, $past(start && !busy))

  // a dropped line byte is still echoed but never counted as stored
  `SPDRB_ASSERT_NOW(a_drop_echo, out_valid && out_item.rx_dropped,
                    out_item.data_valid && !out_item.ok)

  // after a cpu write the transmit ring is non-empty and a send is requested
  `SPDRB_ASSERT_NEXT(a_write_req, start && !busy && in_item.req_type == REQ_TX_WRITE,
                     !out_item.tx_empty && out_item.send_request)

endmodule

bind serial_port_dual_ring_buffer_core spdrb_chk u_spdrb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - serial port dual ring buffer testbench
// drives cpu write, cpu read, line byte and transmitter-ready events into
// the core, keeps its own copy of both rings and checks every result beat
// field by field against the predicted one
// ---------------------------------------------------------------------------
module tb;
  import spdrb_pkg::*;

  localparam int TXD = TX_DEPTH_DEF;
  localparam int RXD = RX_DEPTH_DEF;

  // dut ports, all inputs known from time zero
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  serial_port_dual_ring_buffer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #6 clk = ~clk;

  // shadow copy of the two rings
  logic [7:0] tx_ring [TXD];
  logic [7:0] rx_ring [RXD];
  int         tx_wr = 0, tx_rd = 0, rx_wr = 0, rx_rd = 0;
  logic       send_en = 1'b0;

  // results still owed by the dut, oldest first
  out_item_t  owed_results [$];

  int errors = 0;
  bit gaps_on = 1'b0;

  // tallies for the closing summary
  int n_events = 0, n_writes = 0, n_refused = 0, n_reads = 0, n_read_empty = 0;
  int n_line = 0, n_dropped = 0, n_ready = 0, n_ready_empty = 0;

  function automatic int ring_next(int p, int depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  function automatic int rx_fill();
    return (rx_wr + RXD - rx_rd) % RXD;
  endfunction

  // works out the result beat of one event and moves the shadow rings on
  function automatic out_item_t apply_event(in_item_t ev);
    out_item_t r;
    int        nxt;
    r = '0;
    n_events++;
    case (ev.req_type)
      REQ_TX_WRITE: begin
        n_writes++;
        nxt = ring_next(tx_wr, TXD);
        if (nxt != tx_rd) begin
          tx_ring[tx_wr] = ev.data_in;
          tx_wr = nxt;
          send_en = 1'b1;
          r.ok = 1'b1;
        end else begin
          n_refused++;
        end
      end
      REQ_RX_READ: begin
        n_reads++;
        if (rx_wr != rx_rd) begin
          r.data_out = rx_ring[rx_rd];
          rx_rd = ring_next(rx_rd, RXD);
          r.ok = 1'b1;
          r.data_valid = 1'b1;
        end else begin
          n_read_empty++;
        end
      end
      REQ_LINE_RX: begin
        n_line++;
        nxt = ring_next(rx_wr, RXD);
        if (nxt != rx_rd) begin
          rx_ring[rx_wr] = ev.data_in;
          rx_wr = nxt;
          r.ok = 1'b1;
        end else begin
          r.rx_dropped = 1'b1;
          n_dropped++;
        end
        // line byte is echoed whether stored or not
        r.data_valid = 1'b1;
        r.data_out = ev.data_in;
      end
      default: begin
        n_ready++;
        if (tx_wr == tx_rd) begin
          send_en = 1'b0;
          n_ready_empty++;
        end else begin
          r.data_out = tx_ring[tx_rd];
          tx_rd = ring_next(tx_rd, TXD);
          r.ok = 1'b1;
          r.data_valid = 1'b1;
        end
      end
    endcase
    r.rx_count = 6'(rx_fill());
    r.tx_empty = (tx_wr == tx_rd);
    r.send_request = send_en;
    return r;
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("%s got %0h, wanted %0h", name, got, want));
  endtask

  // one event beat: optional idle burst, then hold start until taken
  task automatic send_event(logic [1:0] req, logic [7:0] b);
    in_item_t ev;
    ev.req_type = req;
    ev.data_in = b;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_item <= ev;
    start <= 1'b1;
    // busy sampled at the edge, before the dut updates it
    do @(posedge clk); while (busy);
    owed_results.push_back(apply_event(ev));
  endtask

  // checker: every strobed beat against the oldest owed result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        report("result beat with nothing owed");
      end else begin
        want = owed_results.pop_front();
        check_field("ok", 8'(out_item.ok), 8'(want.ok));
        check_field("data_valid", 8'(out_item.data_valid), 8'(want.data_valid));
        check_field("data_out", out_item.data_out, want.data_out);
        check_field("rx_dropped", 8'(out_item.rx_dropped), 8'(want.rx_dropped));
        check_field("rx_count", 8'(out_item.rx_count), 8'(want.rx_count));
        check_field("tx_empty", 8'(out_item.tx_empty), 8'(want.tx_empty));
        check_field("send_request", 8'(out_item.send_request),
                    8'(want.send_request));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty-ring corners, byte extremes and each event kind in isolation
  task automatic test_basic_events();
    send_event(REQ_RX_READ, 8'h3C);    // read when empty
    send_event(REQ_TX_READY, 8'hC3);   // ready with empty ring, send request idle
    send_event(REQ_TX_WRITE, 8'h00);
    send_event(REQ_TX_WRITE, 8'hFF);
    send_event(REQ_TX_WRITE, 8'hA5);
    send_event(REQ_TX_READY, 8'h00);
    send_event(REQ_TX_READY, 8'hFF);
    send_event(REQ_TX_READY, 8'h5A);
    send_event(REQ_TX_READY, 8'h12);   // ring now empty: request drops
    send_event(REQ_TX_READY, 8'h34);   // stays dropped
    send_event(REQ_LINE_RX, 8'h00);
    send_event(REQ_LINE_RX, 8'hFF);
    send_event(REQ_LINE_RX, 8'h5A);
    send_event(REQ_RX_READ, 8'hFF);
    send_event(REQ_RX_READ, 8'h00);
    send_event(REQ_RX_READ, 8'h77);
    send_event(REQ_RX_READ, 8'h88);    // empty again
    // both rings busy at once
    send_event(REQ_TX_WRITE, 8'h81);
    send_event(REQ_LINE_RX, 8'h7E);
    send_event(REQ_TX_READY, 8'h00);
    send_event(REQ_RX_READ, 8'h00);
  endtask

  // run both rings into their full state and back out: refused writes,
  // dropped line bytes with echo, then reads and readies past empty
  task automatic test_full_rings();
    repeat (RXD + 2) send_event(REQ_LINE_RX, 8'($urandom_range(0, 255)));
    repeat (TXD + 2) send_event(REQ_TX_WRITE, 8'($urandom_range(0, 255)));
    repeat (RXD + 1) send_event(REQ_RX_READ, 8'($urandom_range(0, 255)));
    repeat (TXD + 1) send_event(REQ_TX_READY, 8'($urandom_range(0, 255)));
  endtask

  // random traffic in blocks, each block leaning towards filling, draining
  // or neither, so the rings swing between empty and full many times
  task automatic test_random_traffic(int n);
    int         lean;
    int         roll;
    logic [1:0] req;
    logic [7:0] b;
    lean = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) begin
        lean = $urandom_range(0, 2);
        // idle bursts on most blocks, none in the closing stretch
        gaps_on = (i < n - 200) && ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      case (lean)
        1:       req = (roll < 40) ? REQ_TX_WRITE : (roll < 80) ? REQ_LINE_RX :
                       (roll < 90) ? REQ_RX_READ : REQ_TX_READY;
        2:       req = (roll < 10) ? REQ_TX_WRITE : (roll < 20) ? REQ_LINE_RX :
                       (roll < 60) ? REQ_RX_READ : REQ_TX_READY;
        default: req = 2'(roll % 4);
      endcase
      case ($urandom_range(0, 15))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_event(req, b);
    end
    gaps_on = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_basic_events();
    test_full_rings();
    test_random_traffic(1320);

    @(negedge clk);
    start <= 1'b0;

    // drain, then a few beats more for anything stray
    waited = 0;
    while (owed_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (owed_results.size() != 0)
      report($sformatf("%0d results never arrived", owed_results.size()));

    $display("covered %0d events: %0d tx writes (%0d refused), %0d rx reads (%0d on empty)",
             n_events, n_writes, n_refused, n_reads, n_read_empty);
    $display("  %0d line bytes (%0d dropped), %0d ready events (%0d with empty ring)",
             n_line, n_dropped, n_ready, n_ready_empty);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
